// ===== rtl/i2cm_pkg.sv =====
// Shared constants for the I2C master bit engine.
`timescale 1ns / 1ps
package i2cm_pkg;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-3:0] REG_ACK_TIMEOUT = '0;

    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_STOP  = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_READ  = 3'd3;
    localparam logic [2:0] CMD_WAIT  = 3'd4;

    localparam logic [1:0] PH_LOW  = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LAST = 2'd2;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

// ===== rtl/i2c_master_bit_engine_unit.sv =====
// I2C master bit engine: one bus tick per item, APB register for the ack timeout.
`timescale 1ns / 1ps
// The result of an item is registered at the edge that accepts it.
// Throughput: one item per cycle; while a result waits, the next item is taken only in the cycle it is read.
// The tick logic is one pass of the bit sequencer between the state and result registers.
// Reset (synchronous, active low): idle, SCL high, SDA released, ack_timeout = 250.
module i2c_master_bit_engine_unit
    import i2cm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_cmd_valid,
    input  logic [2:0]            i_mode,
    input  logic [7:0]            i_write_byte,
    input  logic                  i_send_ack,
    input  logic                  i_sda_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_scl,
    output logic                  o_sda_out,
    output logic                  o_sda_drive,
    output logic                  o_busy_res,
    output logic                  o_done_res,
    output logic [7:0]            o_read_data,
    output logic                  o_ack_missing,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [7:0] r_ack_timeout;

    logic       r_running, n_running;
    logic [2:0] r_cmd, n_cmd;
    logic [3:0] r_bit_count, n_bit_count;
    logic [1:0] r_sub_phase, n_sub_phase;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_poll, n_poll;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic       r_drv, n_drv;
    logic       r_no_ack, n_no_ack;
    logic       r_ack_choice, n_ack_choice;
    logic [7:0] r_last_read, n_last_read;
    logic       n_done;

    logic       r_out_valid;
    logic       r_out_scl, r_out_sda, r_out_drv, r_out_busy, r_out_done, r_out_no_ack;
    logic [7:0] r_out_read;

    logic       in_acc;
    logic       cfg_wr;

    // Values after a possible command start on this tick
    logic       e_running;
    logic [2:0] e_cmd;
    logic [3:0] e_bit_count;
    logic [1:0] e_sub_phase;
    logic [7:0] e_shift;
    logic [7:0] e_poll;
    logic       e_ack_choice;
    logic       e_no_ack;

    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign prdata     = (paddr[APB_ADDR_W-1:2] == REG_ACK_TIMEOUT)
                        ? {{(APB_DATA_W-8){1'b0}}, r_ack_timeout} : '0;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= ACK_TIMEOUT_RST;
        end else if (cfg_wr && (paddr[APB_ADDR_W-1:2] == REG_ACK_TIMEOUT)) begin
            r_ack_timeout <= pwdata[7:0];
        end
    end

    always_comb begin
        e_running    = r_running;
        e_cmd        = r_cmd;
        e_bit_count  = r_bit_count;
        e_sub_phase  = r_sub_phase;
        e_shift      = r_shift;
        e_poll       = r_poll;
        e_ack_choice = r_ack_choice;
        e_no_ack     = r_no_ack;
        if (!r_running && i_cmd_valid && (i_mode <= CMD_WAIT)) begin
            e_running    = 1'b1;
            e_cmd        = i_mode;
            e_bit_count  = '0;
            e_sub_phase  = PH_LOW;
            e_poll       = '0;
            e_shift      = (i_mode == CMD_WRITE) ? i_write_byte : 8'd0;
            e_ack_choice = i_send_ack;
            if (i_mode == CMD_WAIT) begin
                e_no_ack = 1'b0;
            end
        end

        n_running    = e_running;
        n_cmd        = e_cmd;
        n_bit_count  = e_bit_count;
        n_sub_phase  = e_sub_phase;
        n_shift      = e_shift;
        n_poll       = e_poll;
        n_ack_choice = e_ack_choice;
        n_no_ack     = e_no_ack;
        n_last_read  = r_last_read;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_drv        = r_drv;
        n_done       = 1'b0;

        if (e_running) begin
            case (e_cmd)
                CMD_START: begin
                    if (e_sub_phase == PH_LOW) begin
                        {n_scl, n_sda, n_drv} = 3'b111;
                        n_sub_phase = PH_HIGH;
                    end else if (e_sub_phase == PH_HIGH) begin
                        {n_scl, n_sda, n_drv} = 3'b101;
                        n_sub_phase = PH_LAST;
                    end else begin
                        {n_scl, n_sda, n_drv} = 3'b001;
                        n_done = 1'b1;
                    end
                end
                CMD_STOP: begin
                    if (e_sub_phase == PH_LOW) begin
                        {n_scl, n_sda, n_drv} = 3'b001;
                        n_sub_phase = PH_HIGH;
                    end else if (e_sub_phase == PH_HIGH) begin
                        {n_scl, n_sda, n_drv} = 3'b101;
                        n_sub_phase = PH_LAST;
                    end else begin
                        {n_scl, n_sda, n_drv} = 3'b111;
                        n_done = 1'b1;
                    end
                end
                CMD_WRITE: begin
                    if (e_sub_phase == PH_LOW) begin
                        {n_scl, n_sda, n_drv} = {1'b0, e_shift[7], 1'b1};
                        n_sub_phase = PH_HIGH;
                    end else if (e_sub_phase == PH_HIGH) begin
                        {n_scl, n_sda, n_drv} = {1'b1, r_sda, 1'b1};
                        n_sub_phase = PH_LAST;
                    end else begin
                        {n_scl, n_sda, n_drv} = {1'b0, r_sda, 1'b1};
                        n_shift     = {e_shift[6:0], 1'b0};
                        n_sub_phase = PH_LOW;
                        n_bit_count = e_bit_count + 4'd1;
                        if (e_bit_count >= BITS_PER_BYTE - 4'd1) begin
                            n_done = 1'b1;
                        end
                    end
                end
                CMD_READ: begin
                    if (e_bit_count < BITS_PER_BYTE) begin
                        if (e_sub_phase == PH_LOW) begin
                            {n_scl, n_sda, n_drv} = 3'b010;
                            n_sub_phase = PH_HIGH;
                        end else if (e_sub_phase == PH_HIGH) begin
                            {n_scl, n_sda, n_drv} = 3'b110;
                            n_sub_phase = PH_LAST;
                        end else begin
                            {n_scl, n_sda, n_drv} = 3'b110;
                            n_shift     = {e_shift[6:0], i_sda_in};
                            n_sub_phase = PH_LOW;
                            n_bit_count = e_bit_count + 4'd1;
                            if (e_bit_count == BITS_PER_BYTE - 4'd1) begin
                                n_last_read = {e_shift[6:0], i_sda_in};
                            end
                        end
                    end else begin
                        if (e_sub_phase == PH_LOW) begin
                            {n_scl, n_sda, n_drv} = {1'b0, ~e_ack_choice, 1'b1};
                            n_sub_phase = PH_HIGH;
                        end else if (e_sub_phase == PH_HIGH) begin
                            {n_scl, n_sda, n_drv} = {1'b1, ~e_ack_choice, 1'b1};
                            n_sub_phase = PH_LAST;
                        end else begin
                            {n_scl, n_sda, n_drv} = {1'b0, ~e_ack_choice, 1'b1};
                            n_done = 1'b1;
                        end
                    end
                end
                CMD_WAIT: begin
                    if (e_sub_phase == PH_LOW) begin
                        {n_scl, n_sda, n_drv} = 3'b110;
                        n_sub_phase = PH_HIGH;
                    end else if (!i_sda_in) begin
                        {n_scl, n_sda, n_drv} = 3'b010;
                        n_done = 1'b1;
                    end else if (e_poll >= r_ack_timeout) begin
                        // no ack: fall into the first stop tick
                        n_no_ack    = 1'b1;
                        n_cmd       = CMD_STOP;
                        {n_scl, n_sda, n_drv} = 3'b001;
                        n_sub_phase = PH_HIGH;
                    end else begin
                        n_poll = e_poll + 8'd1;
                    end
                end
                default: begin
                    n_done = 1'b1;
                end
            endcase
            if (n_done) begin
                n_running   = 1'b0;
                n_sub_phase = PH_LOW;
                n_bit_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running    <= 1'b0;
            r_cmd        <= CMD_START;
            r_bit_count  <= '0;
            r_sub_phase  <= PH_LOW;
            r_shift      <= '0;
            r_poll       <= '0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_drv        <= 1'b0;
            r_no_ack     <= 1'b0;
            r_ack_choice <= 1'b0;
            r_last_read  <= '0;
        end else if (in_acc) begin
            r_running    <= n_running;
            r_cmd        <= n_cmd;
            r_bit_count  <= n_bit_count;
            r_sub_phase  <= n_sub_phase;
            r_shift      <= n_shift;
            r_poll       <= n_poll;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_drv        <= n_drv;
            r_no_ack     <= n_no_ack;
            r_ack_choice <= n_ack_choice;
            r_last_read  <= n_last_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_scl    <= n_scl;
            r_out_sda    <= n_sda;
            r_out_drv    <= n_drv;
            r_out_busy   <= n_running;
            r_out_done   <= n_done;
            r_out_read   <= n_last_read;
            r_out_no_ack <= n_no_ack;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_scl         = r_out_scl;
    assign o_sda_out     = r_out_sda;
    assign o_sda_drive   = r_out_drv;
    assign o_busy_res    = r_out_busy;
    assign o_done_res    = r_out_done;
    assign o_read_data   = r_out_read;
    assign o_ack_missing = r_out_no_ack;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("done reported while still busy");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_sub_phase == PH_LOW) && (r_bit_count == 4'd0))
        else $error("idle with sequencer not at rest");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= BITS_PER_BYTE)
        else $error("bit counter past one byte");

    a_released_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_drv |-> r_sda)
        else $error("released SDA not reading high");

    a_write_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running && (r_cmd == CMD_WRITE) |-> r_bit_count < BITS_PER_BYTE)
        else $error("write ran past the last bit");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the I2C master bit engine: tick stream, line levels, APB timeout.
`timescale 1ns / 1ps
module tb_top
    import i2cm_pkg::*;
;

    localparam logic [2:0] MODE_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] MODE_UNUSED       = 3'd7;
    localparam int         PHASES            = 6;
    localparam int         PHASE_ITEMS       = 265;
    localparam int         STALL_LIMIT       = 4000;
    localparam int         SND_PCT [PHASES]  = '{0, 88, 0, 38, 0, 38};
    localparam int         RCV_PCT [PHASES]  = '{0, 0, 88, 38, 0, 38};
    localparam logic [7:0] TMO_TAB [PHASES]  = '{8'd1, 8'd255, 8'd0, 8'd0, 8'd255, 8'd3};

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] mode;
        logic [7:0] wbyte;
        logic       send_ack;
        logic       sda;
    } t_tick;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic       busy;
        logic       done;
        logic [7:0] read_data;
        logic       ack_missing;
    } t_bus_out;

    typedef struct {
        t_tick    t;
        int       reps;
        bit       typed;
        t_bus_out want;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n      = 1'b0;
    logic                  i_in_valid   = 1'b0;
    logic                  o_in_ready;
    logic                  i_cmd_valid  = 1'b0;
    logic [2:0]            i_mode       = CMD_START;
    logic [7:0]            i_write_byte = 8'h00;
    logic                  i_send_ack   = 1'b0;
    logic                  i_sda_in     = 1'b1;
    logic                  o_out_valid;
    logic                  i_out_ready  = 1'b0;
    logic                  o_scl;
    logic                  o_sda_out;
    logic                  o_sda_drive;
    logic                  o_busy_res;
    logic                  o_done_res;
    logic [7:0]            o_read_data;
    logic                  o_ack_missing;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0] paddr        = '0;
    logic [APB_DATA_W-1:0] pwdata       = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    i2c_master_bit_engine_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd_valid  (i_cmd_valid),
        .i_mode       (i_mode),
        .i_write_byte (i_write_byte),
        .i_send_ack   (i_send_ack),
        .i_sda_in     (i_sda_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_scl        (o_scl),
        .o_sda_out    (o_sda_out),
        .o_sda_drive  (o_sda_drive),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_read_data  (o_read_data),
        .o_ack_missing(o_ack_missing),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // engine mirror
    logic [2:0] m_cmd;
    logic       m_run;
    logic [3:0] m_bits;
    logic [1:0] m_ph;
    logic [7:0] m_shift;
    logic [7:0] m_polls;
    logic       m_scl;
    logic       m_sda;
    logic       m_drv;
    logic       m_noack;
    logic       m_ackc;
    logic [7:0] m_rd;
    logic [7:0] m_tmo;

    t_bus_out pending_lines_q [$];
    int       n_bad       = 0;
    int       snd_pct     = 0;
    int       rcv_pct     = 0;
    int       sda_style   = 2;
    int       idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function void drive_lines(input logic c, input logic d, input logic e);
        m_scl = c;
        m_sda = d;
        m_drv = e;
    endfunction

    function logic stop_step();
        logic fin;
        fin = 1'b0;
        case (m_ph)
            PH_LOW: begin
                drive_lines(1'b0, 1'b0, 1'b1);
                m_ph = PH_HIGH;
            end
            PH_HIGH: begin
                drive_lines(1'b1, 1'b0, 1'b1);
                m_ph = PH_LAST;
            end
            default: begin
                drive_lines(1'b1, 1'b1, 1'b1);
                fin = 1'b1;
            end
        endcase
        return fin;
    endfunction

    function t_bus_out engine_tick(input t_tick t);
        logic fin;
        logic a;
        fin = 1'b0;
        if (!m_run && t.cmd_valid && t.mode <= CMD_WAIT) begin
            m_run   = 1'b1;
            m_cmd   = t.mode;
            m_bits  = '0;
            m_ph    = PH_LOW;
            m_polls = '0;
            m_shift = (t.mode == CMD_WRITE) ? t.wbyte : 8'h00;
            m_ackc  = t.send_ack;
            if (t.mode == CMD_WAIT) m_noack = 1'b0;
        end
        if (m_run) begin
            case (m_cmd)
                CMD_START: begin
                    case (m_ph)
                        PH_LOW: begin
                            drive_lines(1'b1, 1'b1, 1'b1);
                            m_ph = PH_HIGH;
                        end
                        PH_HIGH: begin
                            drive_lines(1'b1, 1'b0, 1'b1);
                            m_ph = PH_LAST;
                        end
                        default: begin
                            drive_lines(1'b0, 1'b0, 1'b1);
                            fin = 1'b1;
                        end
                    endcase
                end
                CMD_STOP: fin = stop_step();
                CMD_WRITE: begin
                    case (m_ph)
                        PH_LOW: begin
                            drive_lines(1'b0, m_shift[7], 1'b1);
                            m_ph = PH_HIGH;
                        end
                        PH_HIGH: begin
                            drive_lines(1'b1, m_sda, 1'b1);
                            m_ph = PH_LAST;
                        end
                        default: begin
                            drive_lines(1'b0, m_sda, 1'b1);
                            m_shift = m_shift << 1;
                            m_ph    = PH_LOW;
                            m_bits  = m_bits + 4'd1;
                            if (m_bits >= BITS_PER_BYTE) fin = 1'b1;
                        end
                    endcase
                end
                CMD_READ: begin
                    if (m_bits < BITS_PER_BYTE) begin
                        case (m_ph)
                            PH_LOW: begin
                                drive_lines(1'b0, 1'b1, 1'b0);
                                m_ph = PH_HIGH;
                            end
                            PH_HIGH: begin
                                drive_lines(1'b1, 1'b1, 1'b0);
                                m_ph = PH_LAST;
                            end
                            default: begin
                                drive_lines(1'b1, 1'b1, 1'b0);
                                m_shift = {m_shift[6:0], t.sda};
                                m_ph    = PH_LOW;
                                m_bits  = m_bits + 4'd1;
                                if (m_bits == BITS_PER_BYTE) m_rd = m_shift;
                            end
                        endcase
                    end else begin
                        a = ~m_ackc;
                        case (m_ph)
                            PH_LOW: begin
                                drive_lines(1'b0, a, 1'b1);
                                m_ph = PH_HIGH;
                            end
                            PH_HIGH: begin
                                drive_lines(1'b1, a, 1'b1);
                                m_ph = PH_LAST;
                            end
                            default: begin
                                drive_lines(1'b0, a, 1'b1);
                                fin = 1'b1;
                            end
                        endcase
                    end
                end
                CMD_WAIT: begin
                    if (m_ph == PH_LOW) begin
                        drive_lines(1'b1, 1'b1, 1'b0);
                        m_ph = PH_HIGH;
                    end else if (!t.sda) begin
                        drive_lines(1'b0, 1'b1, 1'b0);
                        fin = 1'b1;
                    end else if (m_polls >= m_tmo) begin
                        // no ack: fall into a stop on this same tick
                        m_noack = 1'b1;
                        m_cmd   = CMD_STOP;
                        m_ph    = PH_LOW;
                        fin     = stop_step();
                    end else begin
                        m_polls = m_polls + 8'd1;
                    end
                end
                default: fin = 1'b1;
            endcase
            if (fin) begin
                m_run  = 1'b0;
                m_ph   = PH_LOW;
                m_bits = '0;
            end
        end
        return {m_scl, m_sda, m_drv, m_run, fin, m_rd, m_noack};
    endfunction

    // random tick shaped around the mirror: commands mostly when idle
    function t_tick make_tick();
        t_tick t;
        int    pick;
        case ($urandom_range(0, 7))
            0:       t.wbyte = 8'h00;
            1:       t.wbyte = 8'hFF;
            2:       t.wbyte = 8'h80;
            3:       t.wbyte = 8'h01;
            default: t.wbyte = 8'($urandom_range(0, 255));
        endcase
        t.send_ack = 1'($urandom_range(0, 1));
        if (!m_run) begin
            t.cmd_valid = ($urandom_range(0, 9) != 0);
            pick = $urandom_range(0, 19);
            if (pick < 3)       t.mode = CMD_START;
            else if (pick < 6)  t.mode = CMD_STOP;
            else if (pick < 10) t.mode = CMD_WRITE;
            else if (pick < 14) t.mode = CMD_READ;
            else if (pick < 19) t.mode = CMD_WAIT;
            else                t.mode = 3'($urandom_range(MODE_FIRST_UNUSED, MODE_UNUSED));
            if (t.cmd_valid) sda_style = $urandom_range(0, 3);
        end else begin
            t.cmd_valid = ($urandom_range(0, 3) == 0);
            t.mode      = 3'($urandom_range(0, 7));
        end
        case (sda_style)
            0:       t.sda = 1'b0;
            1:       t.sda = 1'b1;
            2:       t.sda = 1'($urandom_range(0, 1));
            default: t.sda = ($urandom_range(0, 49) != 0);
        endcase
        return t;
    endfunction

    task automatic cmp_field(input string f, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", f, want, got);
            n_bad++;
        end
    endtask

    task automatic send_tick(input t_tick t, input bit typed, input t_bus_out want);
        t_bus_out pred;
        while ($urandom_range(0, 99) < snd_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd_valid  <= t.cmd_valid;
        i_mode       <= t.mode;
        i_write_byte <= t.wbyte;
        i_send_ack   <= t.send_ack;
        i_sda_in     <= t.sda;
        // ready is settled mid-cycle; the following edge takes the item
        @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
        pred = engine_tick(t);
        pending_lines_q.push_back(typed ? want : pred);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_lines_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_ack_timeout(input logic [7:0] tmo);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ACK_TIMEOUT, 2'b00};
        pwdata  <= {24'h0, tmo};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        m_tmo   = tmo;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        cmp_field("ack_timeout", tmo, prdata[7:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= rcv_pct);
    end

    always @(posedge i_clk) begin
        t_bus_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_lines_q.size() == 0) begin
                $error("result item with nothing pending");
                n_bad++;
            end else begin
                want = pending_lines_q.pop_front();
                cmp_field("scl", 8'(want.scl), 8'(o_scl));
                cmp_field("sda_out", 8'(want.sda_out), 8'(o_sda_out));
                cmp_field("sda_drive", 8'(want.sda_drive), 8'(o_sda_drive));
                cmp_field("busy_res", 8'(want.busy), 8'(o_busy_res));
                cmp_field("done_res", 8'(want.done), 8'(o_done_res));
                cmp_field("read_data", want.read_data, o_read_data);
                cmp_field("ack_missing", 8'(want.ack_missing), 8'(o_ack_missing));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_dir_row   rows [$];
        logic [7:0] tmo;

        m_cmd = CMD_START; m_run = 1'b0; m_bits = '0; m_ph = PH_LOW;
        m_shift = '0; m_polls = '0; m_noack = 1'b0; m_ackc = 1'b0; m_rd = '0;
        m_tmo = ACK_TIMEOUT_RST;
        drive_lines(1'b1, 1'b1, 1'b0);

        // want = {scl sda drv busy done, read_data, ack_missing}
        rows.push_back('{{1'b0, CMD_START, 8'h00, 1'b0, 1'b1}, 1, 1'b1, {5'b11000, 8'h00, 1'b0}});
        rows.push_back('{{1'b1, MODE_UNUSED, 8'h00, 1'b0, 1'b1}, 1, 1'b1,
                         {5'b11000, 8'h00, 1'b0}});
        rows.push_back('{{1'b1, CMD_START, 8'h00, 1'b0, 1'b1}, 1, 1'b1, {5'b11110, 8'h00, 1'b0}});
        rows.push_back('{{1'b0, CMD_START, 8'h00, 1'b0, 1'b1}, 1, 1'b1, {5'b10110, 8'h00, 1'b0}});
        rows.push_back('{{1'b0, CMD_START, 8'h00, 1'b0, 1'b1}, 1, 1'b1, {5'b00101, 8'h00, 1'b0}});
        // zero timeout: first high poll turns into a stop
        rows.push_back('{{1'b1, CMD_WAIT, 8'h00, 1'b0, 1'b1}, 1, 1'b1, {5'b11010, 8'h00, 1'b0}});
        rows.push_back('{{1'b0, CMD_START, 8'h00, 1'b0, 1'b1}, 1, 1'b1, {5'b00110, 8'h00, 1'b1}});
        rows.push_back('{{1'b1, CMD_START, 8'h00, 1'b0, 1'b1}, 1, 1'b1, {5'b10110, 8'h00, 1'b1}});
        rows.push_back('{{1'b0, CMD_START, 8'h00, 1'b0, 1'b1}, 1, 1'b1, {5'b11101, 8'h00, 1'b1}});
        // new wait-ack clears the flag, acked on first poll
        rows.push_back('{{1'b1, CMD_WAIT, 8'h00, 1'b0, 1'b0}, 1, 1'b1, {5'b11010, 8'h00, 1'b0}});
        rows.push_back('{{1'b0, CMD_START, 8'h00, 1'b0, 1'b0}, 1, 1'b1, {5'b01001, 8'h00, 1'b0}});
        rows.push_back('{{1'b1, CMD_STOP, 8'h00, 1'b0, 1'b1}, 1, 1'b1, {5'b00110, 8'h00, 1'b0}});
        rows.push_back('{{1'b0, CMD_START, 8'h00, 1'b0, 1'b1}, 1, 1'b1, {5'b10110, 8'h00, 1'b0}});
        rows.push_back('{{1'b0, CMD_START, 8'h00, 1'b0, 1'b1}, 1, 1'b1, {5'b11101, 8'h00, 1'b0}});
        // write with stop commands arriving while busy, then an acked read of 8'hFF
        rows.push_back('{{1'b1, CMD_WRITE, 8'h80, 1'b0, 1'b0}, 1, 1'b0, '0});
        rows.push_back('{{1'b1, CMD_STOP, 8'hFF, 1'b1, 1'b1}, 23, 1'b0, '0});
        rows.push_back('{{1'b1, CMD_READ, 8'h00, 1'b1, 1'b1}, 1, 1'b0, '0});
        rows.push_back('{{1'b0, CMD_START, 8'h00, 1'b0, 1'b1}, 26, 1'b0, '0});
        rows.push_back('{{1'b0, CMD_START, 8'h00, 1'b0, 1'b1}, 1, 1'b1, {5'b00100, 8'hFF, 1'b0}});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_ack_timeout(8'd0);

        foreach (rows[r]) begin
            repeat (rows[r].reps) send_tick(rows[r].t, rows[r].typed, rows[r].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            snd_pct = SND_PCT[p];
            rcv_pct = RCV_PCT[p];
            tmo = (p == 3) ? 8'($urandom_range(2, 254)) : TMO_TAB[p];
            set_ack_timeout(tmo);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2 || $urandom_range(0, 149) == 0) drain_results();
                send_tick(make_tick(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (4) @(posedge i_clk);
        if (n_bad == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/i2cm_pkg.sv
rtl/i2c_master_bit_engine_unit.sv
tb/sv/tb_top.sv
